FILE: rtl/isqs_pkg.sv
package isqs_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT_FRONT = 3'd0,
      ACT_INSERT_BACK  = 3'd1,
      ACT_INSERT_AT    = 3'd2,
      ACT_REMOVE_FRONT = 3'd3,
      ACT_REMOVE_BACK  = 3'd4,
      ACT_REMOVE_AT    = 3'd5,
      ACT_READ_AT      = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_PUT   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

endpackage

FILE: rtl/isqs_ram.sv
module isqs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/indexed_sequence_store_top.sv
// Ordered store of up to DEPTH signed 32-bit values in one synchronous RAM.
// Request channel (req_*): action, value, position; a beat is taken when
// req_valid is high and req_stall is low. Response channel (rsp_*): status,
// result_value and fill_count, one beat per request, taken when rsp_valid
// is high and rsp_stall is low.
// Steps per request, n = entries held, p = position:
//   any rejected request: straight to the response
//   insert at p = n (insert at the back, or any insert into an empty store): put only
//   insert at p < n: words n-1 down to p moved up, one RAM word per cycle, then put
//   remove at p: word p taken as result, words above it moved down, one RAM word per cycle
//   read at p: word p read and taken as result
// The single write port and the registered RAM read set the shift rate of one
// entry per cycle. One request is worked on at a time; the next is taken as
// soon as the previous one sits in the response register, even if that
// response is stalled. A stalled response holds its payload and delays the
// completion of the following request until it is taken.
// Reset empties the store at once: no clearing pass, RAM content untouched.
module indexed_sequence_store_top
   import isqs_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ACTION_W-1:0]                  req_action,
   input  logic signed [DATA_W-1:0]             req_value,
   input  logic [$clog2(DEPTH+1)-1:0]           req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [STATUS_W-1:0]                  rsp_status,
   output logic signed [DATA_W-1:0]             rsp_result_value,
   output logic [$clog2(DEPTH+1)-1:0]           rsp_fill_count
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   status_type        status_ff, status_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     end_ff, end_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [AW-1:0]     rd_addr_ff, rd_addr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CW-1:0]     rsp_count_ff, rsp_count_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [DATA_W-1:0] mem_rdata;

   logic [CW-1:0]     eff_pos;
   logic              rsp_free;

   isqs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      result_in     = result_ff;
      rd_valid_in   = 1'b0;
      rd_addr_in    = rd_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_addr_ff;
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff;
      eff_pos       = req_position;

      // move the word read last cycle, or capture it as the result
      if (rd_valid_ff) begin
         if (kind_ff == KIND_INSERT) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(rd_addr_ff + AW'(1));
         end else if (rd_addr_ff == pos_ff) begin
            result_in = mem_rdata;
         end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(rd_addr_ff - AW'(1));
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               result_in = '0;
               val_in    = $unsigned(req_value);
               state_in  = S_DONE;
               status_in = ST_BAD;
               kind_in   = KIND_READ;
               unique case (req_action)
                  ACT_INSERT_FRONT: eff_pos = '0;
                  ACT_INSERT_BACK:  eff_pos = count_ff;
                  ACT_REMOVE_FRONT: eff_pos = '0;
                  ACT_REMOVE_BACK:  eff_pos = CW'(count_ff - CW'(1));
                  default:          eff_pos = req_position;
               endcase
               pos_in = AW'(eff_pos);
               unique case (req_action)
                  ACT_INSERT_FRONT, ACT_INSERT_BACK, ACT_INSERT_AT: begin
                     kind_in = KIND_INSERT;
                     if (eff_pos > count_ff) begin
                        status_in = ST_BAD;
                     end else if (count_ff == CW'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                        idx_in    = AW'(count_ff - CW'(1));
                        end_in    = AW'(eff_pos);
                        state_in  = (eff_pos == count_ff) ? S_PUT : S_SCAN;
                     end
                  end
                  ACT_REMOVE_FRONT, ACT_REMOVE_BACK, ACT_REMOVE_AT: begin
                     kind_in = KIND_REMOVE;
                     if (count_ff != '0 && eff_pos < count_ff) begin
                        status_in = ST_OK;
                        idx_in    = AW'(eff_pos);
                        end_in    = AW'(count_ff - CW'(1));
                        state_in  = S_SCAN;
                     end
                  end
                  ACT_READ_AT: begin
                     kind_in = KIND_READ;
                     if (eff_pos < count_ff) begin
                        status_in = ST_OK;
                        idx_in    = AW'(eff_pos);
                        end_in    = AW'(eff_pos);
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = ST_BAD;
                  end
               endcase
            end
         end
         S_SCAN: begin
            mem_re      = 1'b1;
            mem_raddr   = idx_ff;
            rd_valid_in = 1'b1;
            rd_addr_in  = idx_ff;
            if (idx_ff == end_ff) begin
               state_in = S_DRAIN;
            end else if (kind_ff == KIND_INSERT) begin
               idx_in = AW'(idx_ff - AW'(1));
            end else begin
               idx_in = AW'(idx_ff + AW'(1));
            end
         end
         S_DRAIN: begin
            state_in = (kind_ff == KIND_INSERT) ? S_PUT : S_DONE;
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               if (status_ff == ST_OK && kind_ff == KIND_INSERT) begin
                  count_in = CW'(count_ff + CW'(1));
               end else if (status_ff == ST_OK && kind_ff == KIND_REMOVE) begin
                  count_in = CW'(count_ff - CW'(1));
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = (status_ff == ST_OK) ? result_ff : '0;
               rsp_count_in  = count_in;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      result_ff     <= result_in;
      rd_addr_ff    <= rd_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = $signed(rsp_value_ff);
   assign rsp_fill_count   = rsp_count_ff;

endmodule

FILE: bench/indexed_sequence_store_top_test.sv
`timescale 1ns / 100ps

module indexed_sequence_store_top_test;
   import isqs_pkg::*;

   localparam int unsigned DEPTH = 64;
   localparam int unsigned POS_W = $clog2(DEPTH + 1);
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         fill;
   } store_reply_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [ACTION_W-1:0]      req_action = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [POS_W-1:0]         rsp_fill_count;

   logic signed [DATA_W-1:0] held_values[$];
   store_reply_type          awaited_replies[$];
   int                       fail_count = 0;
   int                       cycle_count = 0;
   int                       holdoff_cycles = 0;
   bit                       steady = 1'b0;

   indexed_sequence_store_top #(.DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_value(rsp_result_value),
      .rsp_fill_count  (rsp_fill_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [STATUS_W-1:0] place_value(input int pos,
                                                      input logic signed [DATA_W-1:0] val);
      if (pos > held_values.size()) return ST_BAD;
      if (held_values.size() >= DEPTH) return ST_FULL;
      held_values.insert(pos, val);
      return ST_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] take_value(input int pos,
                                                     output logic signed [DATA_W-1:0] val);
      val = '0;
      if (pos >= held_values.size()) return ST_BAD;
      val = held_values[pos];
      held_values.delete(pos);
      return ST_OK;
   endfunction

   function automatic store_reply_type predict_reply(input logic [ACTION_W-1:0] act,
                                                     input logic signed [DATA_W-1:0] val,
                                                     input logic [POS_W-1:0] pos);
      store_reply_type          r;
      logic signed [DATA_W-1:0] taken;
      r.status = ST_BAD;
      taken = '0;
      case (act)
         ACT_INSERT_FRONT: r.status = place_value(0, val);
         ACT_INSERT_BACK:  r.status = place_value(held_values.size(), val);
         ACT_INSERT_AT:    r.status = place_value(int'(pos), val);
         ACT_REMOVE_FRONT: r.status = take_value(0, taken);
         ACT_REMOVE_BACK: begin
            if (held_values.size() != 0)
               r.status = take_value(held_values.size() - 1, taken);
         end
         ACT_REMOVE_AT:    r.status = take_value(int'(pos), taken);
         ACT_READ_AT: begin
            if (int'(pos) < held_values.size()) begin
               r.status = ST_OK;
               taken = held_values[pos];
            end
         end
         default: ;
      endcase
      r.value = (r.status == ST_OK) ? taken : '0;
      r.fill = POS_W'(held_values.size());
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // valid stays high after the beat; the next call or stop_sending decides its level
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic signed [DATA_W-1:0] val, input int pos);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_value    <= val;
      req_position <= POS_W'(pos);
      do @(posedge clock); while (req_stall);
      awaited_replies.push_back(predict_reply(act, val, POS_W'(pos)));
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   task automatic pause_until_drained();
      stop_sending();
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_item(input int insert_pct);
      int roll;
      int n;
      logic [ACTION_W-1:0] act;
      int pos;
      roll = $urandom_range(0, 99);
      n = held_values.size();
      if (roll < 5) begin
         act = ACTION_W'($urandom_range(0, 7));
         pos = $urandom_range(0, DEPTH);
      end else if (roll < 5 + insert_pct) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_INSERT_FRONT;
            1:       act = ACT_INSERT_BACK;
            default: act = ACT_INSERT_AT;
         endcase
         pos = $urandom_range(0, n);
      end else begin
         case ($urandom_range(0, 3))
            0:       act = ACT_REMOVE_FRONT;
            1:       act = ACT_REMOVE_BACK;
            2:       act = ACT_REMOVE_AT;
            default: act = ACT_READ_AT;
         endcase
         pos = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, DEPTH);
      end
      send_request(act, random_value(), pos);
   endtask

   task automatic test_empty_store();
      send_request(ACT_REMOVE_FRONT, 32'sd5, 0);
      send_request(ACT_REMOVE_BACK, 32'sd6, 0);
      send_request(ACT_REMOVE_AT, 32'sd7, 0);
      send_request(ACT_READ_AT, 32'sd8, 0);
      send_request(ACT_INSERT_AT, 32'sd9, 1);
      send_request(ACT_UNDEFINED, 32'sh1234_5678, 0);
   endtask

   task automatic test_basic_operations();
      send_request(ACT_INSERT_FRONT, 32'sh7FFF_FFFF, 0);
      send_request(ACT_INSERT_BACK, 32'sh8000_0000, 0);
      send_request(ACT_INSERT_AT, 32'sd0, 1);
      send_request(ACT_INSERT_AT, -32'sd1, 3);
      send_request(ACT_INSERT_AT, 32'sd1, 0);
      send_request(ACT_READ_AT, 32'sd0, 0);
      send_request(ACT_READ_AT, 32'sd0, 4);
      send_request(ACT_READ_AT, 32'sd0, 5);
      send_request(ACT_READ_AT, 32'sd0, DEPTH);
      send_request(ACT_INSERT_AT, 32'sd3, DEPTH);
      send_request(ACT_UNDEFINED, -32'sd1, 2);
      send_request(ACT_REMOVE_AT, 32'sd0, 2);
      send_request(ACT_REMOVE_FRONT, 32'sd0, 0);
      send_request(ACT_REMOVE_BACK, 32'sd0, 0);
      send_request(ACT_REMOVE_AT, 32'sd0, 1);
      send_request(ACT_READ_AT, 32'sd0, 0);
      stop_sending();
   endtask

   task automatic test_capacity_limits();
      steady = 1'b1;
      while (held_values.size() < DEPTH) send_random_item(95);
      send_request(ACT_INSERT_FRONT, 32'sd11, 0);
      send_request(ACT_INSERT_BACK, 32'sd12, 0);
      send_request(ACT_INSERT_AT, 32'sd13, 0);
      send_request(ACT_INSERT_AT, 32'sd14, DEPTH);
      send_request(ACT_READ_AT, 32'sd0, DEPTH - 1);
      send_request(ACT_READ_AT, 32'sd0, DEPTH);
      send_request(ACT_REMOVE_AT, 32'sd0, DEPTH - 1);
      send_request(ACT_INSERT_AT, 32'sd15, DEPTH);
      send_request(ACT_INSERT_AT, 32'sd16, DEPTH - 1);
      send_request(ACT_REMOVE_AT, 32'sd0, 0);
      send_request(ACT_INSERT_AT, 32'sd17, 0);
      steady = 1'b0;
      while (held_values.size() > 0) send_random_item(0);
      send_request(ACT_REMOVE_FRONT, 32'sd0, 0);
      stop_sending();
   endtask

   task automatic test_random_mix();
      repeat (220) send_random_item(70);
      pause_until_drained();
      repeat (220) send_random_item(25);
      steady = 1'b1;
      repeat (60) send_random_item(50);
      steady = 1'b0;
      repeat (200) send_random_item(48);
      stop_sending();
   endtask

   task automatic test_response_backpressure();
      steady = 1'b1;
      holdoff_cycles = 300;
      repeat (30) send_random_item(55);
      steady = 1'b0;
      stop_sending();
   endtask

   initial begin
      int pause;
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (holdoff_cycles) @(posedge clock);
            holdoff_cycles = 0;
            rsp_stall <= 1'b0;
         end else begin
            pause = steady ? 0 : $urandom_range(0, 4);
            if (pause > 0) begin
               rsp_stall <= 1'b1;
               repeat (pause) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
         do @(posedge clock); while (!rsp_valid && holdoff_cycles == 0);
      end
   end

   always @(posedge clock) begin
      store_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_result_value !== want.value) begin
               $error("result_value: expected %0d, got %0d", want.value, rsp_result_value);
               fail_count++;
            end
            if (rsp_fill_count !== want.fill) begin
               $error("fill_count: expected %0d, got %0d", want.fill, rsp_fill_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_basic_operations();
      test_capacity_limits();
      test_random_mix();
      test_response_backpressure();
      pause_until_drained();
      repeat (DEPTH + 8) @(posedge clock);
      if (fail_count == 0 && awaited_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: indexed_sequence_store_top.f
rtl/isqs_pkg.sv
rtl/isqs_ram.sv
rtl/indexed_sequence_store_top.sv
bench/indexed_sequence_store_top_test.sv
